>>> hdl/rclfr_pkg.sv
// rclfr_pkg: shared types and constants for the rc link frame receiver
`timescale 1ns / 1ps
`default_nettype none

package rclfr_pkg;

  // run of stored bytes sent for a good channel frame
  localparam int RC_DATA_BYTES = 22;
  localparam int STORE_DEPTH   = 24;
  localparam int IDX_W         = 6;
  localparam int CNT_W         = 5;
  localparam int POS_W         = 5;
  localparam int ADDR_W        = 5;

  // length codes found in byte 0
  localparam logic [7:0] LEN_CODE_8CH  = 8'h0D;
  localparam logic [7:0] LEN_CODE_16CH = 8'h18;
  localparam logic [7:0] LEN_CODE_24CH = 8'h23;
  localparam logic [7:0] LEN_CODE_DL   = 8'h08;

  // frame lengths in bytes
  localparam logic [IDX_W-1:0] LEN_8CH  = 6'd16;
  localparam logic [IDX_W-1:0] LEN_16CH = 6'd27;
  localparam logic [IDX_W-1:0] LEN_24CH = 6'd38;
  localparam logic [IDX_W-1:0] LEN_DL   = 6'd10;
  localparam logic [IDX_W-1:0] LEN_MIN  = 6'd2;

  // channel counts announced by the header
  localparam logic [CNT_W-1:0] CH_8  = 5'd8;
  localparam logic [CNT_W-1:0] CH_16 = 5'd16;
  localparam logic [CNT_W-1:0] CH_24 = 5'd24;

  localparam logic [7:0] TYPE_BYTE = 8'hFF;
  localparam logic [7:0] SUM_GOOD  = 8'hFF;
  localparam logic [7:0] PRIM_POLL = 8'h10;

  // store slots read at fixed places
  localparam logic [ADDR_W-1:0] SLOT_ID    = 5'd1;
  localparam logic [ADDR_W-1:0] SLOT_PRIM  = 5'd2;
  localparam logic [ADDR_W-1:0] SLOT_FLAGS = 5'd23;

  typedef enum logic [1:0] {
    KIND_DATA  = 2'd0,
    KIND_POLL  = 2'd1,
    KIND_ERROR = 2'd2
  } rclfr_kind_t;

  typedef enum logic [2:0] {
    ERR_NONE     = 3'd0,
    ERR_LENGTH   = 3'd1,
    ERR_TYPE     = 3'd2,
    ERR_CHECKSUM = 3'd3,
    ERR_CHANNELS = 3'd4
  } rclfr_err_t;

  // commands from the controller to the datapath
  typedef struct packed {
    logic take;
    logic run_load;
    logic cfg_we;
  } rclfr_cmd_t;

  // status from the datapath to the controller
  typedef struct packed {
    logic out_free;
    logic run_start;
    logic run_last;
  } rclfr_stat_t;

endpackage

`default_nettype wire

>>> hdl/rclfr_ctrl.sv
// rclfr_ctrl: state machine that sequences byte intake and the data run
`timescale 1ns / 1ps
`default_nettype none

module rclfr_ctrl
  import rclfr_pkg::*;
(
  input  wire         clk,
  input  wire         rst,
  input  wire         in_valid,
  output logic        in_stall,
  input  wire         cfg_valid,
  output logic        cfg_ready,
  input  rclfr_stat_t stat,
  output rclfr_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_TAKE = 2'b01,
    ST_RUN  = 2'b10
  } state_t;

  state_t state;
  state_t state_next;

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_TAKE;
    end else begin
      state <= state_next;
    end
  end

  // next state and commands
  always_comb begin
    state_next   = state;
    in_stall     = 1'b1;
    cfg_ready    = 1'b0;
    cmd.take     = 1'b0;
    cmd.run_load = 1'b0;
    cmd.cfg_we   = 1'b0;
    case (state)
      ST_TAKE: begin
        in_stall   = !stat.out_free;
        cfg_ready  = 1'b1;
        cmd.cfg_we = cfg_valid;
        cmd.take   = in_valid && stat.out_free;
        if (cmd.take && stat.run_start) begin
          state_next = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd.run_load = stat.out_free;
        if (stat.out_free && stat.run_last) begin
          state_next = ST_TAKE;
        end
      end
      default: begin
        state_next = ST_TAKE;
      end
    endcase
  end

endmodule

`default_nettype wire

>>> hdl/rclfr_datapath.sv
// rclfr_datapath: frame state, byte store, checksum and output register
`timescale 1ns / 1ps
`default_nettype none

module rclfr_datapath
  import rclfr_pkg::*;
(
  input  wire               clk,
  input  wire               rst,
  input  rclfr_cmd_t        cmd,
  output rclfr_stat_t       stat,
  input  wire  [7:0]        rx_byte,
  input  wire               gap_before,
  input  wire  [7:0]        device_id,
  input  wire               out_stall,
  output logic              out_valid,
  output logic [1:0]        result_kind,
  output logic [2:0]        error_code,
  output logic [7:0]        channel_byte,
  output logic [POS_W-1:0]  byte_position,
  output logic              missing_flag,
  output logic              failsafe_flag,
  output logic              last_of_run
);

  localparam logic [POS_W-1:0] RUN_LAST = POS_W'(RC_DATA_BYTES - 1);
  localparam logic [IDX_W-1:0] STORE_END = IDX_W'(STORE_DEPTH);

  // frame state
  logic [IDX_W-1:0] byte_index;
  logic [IDX_W-1:0] frame_length;
  logic             is_downlink;
  logic [CNT_W-1:0] channel_count;
  logic [7:0]       running_sum;
  logic [7:0]       dev_id;
  logic [7:0]       frame_store [STORE_DEPTH];
  logic [POS_W-1:0] run_cnt;
  logic [ADDR_W-1:0] run_addr;

  // step results
  logic [IDX_W-1:0] idx_eff;
  logic [IDX_W-1:0] idx_inc;
  logic [IDX_W-1:0] byte_index_next;
  logic [IDX_W-1:0] frame_length_next;
  logic             is_downlink_next;
  logic [CNT_W-1:0] channel_count_next;
  logic [7:0]       running_sum_next;
  logic [8:0]       sum_full;
  logic [7:0]       sum_acc;
  logic             proceed;
  logic             store_we;
  logic             single;
  rclfr_kind_t      single_kind;
  rclfr_err_t       single_err;
  logic             run_start;
  logic             out_load;

  // one received byte against the current frame state
  always_comb begin
    idx_eff            = gap_before ? '0 : byte_index;
    idx_inc            = idx_eff + 6'd1;
    sum_full           = {1'b0, running_sum} + {1'b0, rx_byte};
    sum_acc            = sum_full[7:0] + {7'd0, sum_full[8]};
    byte_index_next    = idx_eff;
    frame_length_next  = frame_length;
    is_downlink_next   = is_downlink;
    channel_count_next = channel_count;
    running_sum_next   = running_sum;
    proceed            = 1'b1;
    store_we           = 1'b0;
    single             = 1'b0;
    single_kind        = KIND_ERROR;
    single_err         = ERR_NONE;
    run_start          = 1'b0;

    if (idx_eff == '0) begin
      running_sum_next = '0;
      case (rx_byte)
        LEN_CODE_8CH: begin
          frame_length_next  = LEN_8CH;
          channel_count_next = CH_8;
          is_downlink_next   = 1'b0;
        end
        LEN_CODE_16CH: begin
          frame_length_next  = LEN_16CH;
          channel_count_next = CH_16;
          is_downlink_next   = 1'b0;
        end
        LEN_CODE_24CH: begin
          frame_length_next  = LEN_24CH;
          channel_count_next = CH_24;
          is_downlink_next   = 1'b0;
        end
        LEN_CODE_DL: begin
          frame_length_next = LEN_DL;
          is_downlink_next  = 1'b1;
        end
        default: begin
          proceed          = 1'b0;
          running_sum_next = running_sum;
          single           = 1'b1;
          single_err       = ERR_LENGTH;
        end
      endcase
    end else if (idx_eff == 6'd1 && !is_downlink && rx_byte != TYPE_BYTE) begin
      proceed         = 1'b0;
      byte_index_next = '0;
      single          = 1'b1;
      single_err      = ERR_TYPE;
    end else begin
      running_sum_next = sum_acc;
    end

    // frame end checks
    if (proceed) begin
      store_we        = idx_eff < STORE_END;
      byte_index_next = idx_inc;
      if (frame_length_next > LEN_MIN && idx_inc == frame_length_next) begin
        byte_index_next = '0;
        if (running_sum_next != SUM_GOOD) begin
          single     = 1'b1;
          single_err = ERR_CHECKSUM;
        end else if (channel_count_next != CH_16) begin
          single     = 1'b1;
          single_err = ERR_CHANNELS;
        end else if (is_downlink_next) begin
          if (frame_store[SLOT_ID] == dev_id && frame_store[SLOT_PRIM] == PRIM_POLL) begin
            single      = 1'b1;
            single_kind = KIND_POLL;
          end
        end else begin
          run_start = 1'b1;
        end
      end
    end
  end

  // frame state registers
  always_ff @(posedge clk) begin
    if (rst) begin
      byte_index    <= '0;
      frame_length  <= '0;
      is_downlink   <= 1'b0;
      channel_count <= '0;
      running_sum   <= '0;
    end else if (cmd.take) begin
      byte_index    <= byte_index_next;
      frame_length  <= frame_length_next;
      is_downlink   <= is_downlink_next;
      channel_count <= channel_count_next;
      running_sum   <= running_sum_next;
    end
  end

  // device id register
  always_ff @(posedge clk) begin
    if (rst) begin
      dev_id <= '0;
    end else if (cmd.cfg_we) begin
      dev_id <= device_id;
    end
  end

  // byte store
  always_ff @(posedge clk) begin
    if (cmd.take && store_we) begin
      frame_store[idx_eff[ADDR_W-1:0]] <= rx_byte;
    end
  end

  // run position counter
  always_ff @(posedge clk) begin
    if (rst) begin
      run_cnt <= '0;
    end else if (cmd.take) begin
      run_cnt <= '0;
    end else if (cmd.run_load) begin
      run_cnt <= run_cnt + 5'd1;
    end
  end

  assign run_addr = run_cnt + 5'd1;

  // output register
  assign out_load = (cmd.take && single) || cmd.run_load;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (out_load) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.run_load) begin
      result_kind   <= KIND_DATA;
      error_code    <= ERR_NONE;
      channel_byte  <= frame_store[run_addr];
      byte_position <= run_cnt;
      missing_flag  <= frame_store[SLOT_FLAGS][2];
      failsafe_flag <= frame_store[SLOT_FLAGS][3];
      last_of_run   <= run_cnt == RUN_LAST;
    end else if (cmd.take && single) begin
      result_kind   <= single_kind;
      error_code    <= single_err;
      channel_byte  <= '0;
      byte_position <= '0;
      missing_flag  <= 1'b0;
      failsafe_flag <= 1'b0;
      last_of_run   <= 1'b1;
    end
  end

  // status to the controller
  assign stat.out_free  = !out_valid || !out_stall;
  assign stat.run_start = run_start;
  assign stat.run_last  = run_cnt == RUN_LAST;

endmodule

`default_nettype wire

>>> hdl/rc_link_frame_receiver_core.sv
// rc_link_frame_receiver_core: top level of the rc link frame receiver
//
//   channel | direction | handshake              | payload
//   in      | input     | in_valid / in_stall    | rx_byte, gap_before
//   out     | output    | out_valid / out_stall  | result_kind, error_code, channel_byte,
//           |           |                        | byte_position, missing_flag,
//           |           |                        | failsafe_flag, last_of_run
//   cfg     | input     | cfg_valid / cfg_ready  | device_id
//
// One received byte is taken per cycle while the output register is free.
// A byte that ends a good channel frame starts a run of 22 results, one per
// cycle as the output side takes them; input is stalled until the run's last
// request is loaded.
// Reset is synchronous; it clears the frame state, the device id and the output valid.
// A stalled output holds its request and stalls the input until that request is taken.
`timescale 1ns / 1ps
`default_nettype none

module rc_link_frame_receiver_core
  import rclfr_pkg::*;
(
  input  wire              clk,
  input  wire              rst,
  input  wire              in_valid,
  output logic             in_stall,
  input  wire  [7:0]       rx_byte,
  input  wire              gap_before,
  output logic             out_valid,
  input  wire              out_stall,
  output logic [1:0]       result_kind,
  output logic [2:0]       error_code,
  output logic [7:0]       channel_byte,
  output logic [POS_W-1:0] byte_position,
  output logic             missing_flag,
  output logic             failsafe_flag,
  output logic             last_of_run,
  input  wire              cfg_valid,
  output logic             cfg_ready,
  input  wire  [7:0]       device_id
);

  rclfr_cmd_t  cmd;
  rclfr_stat_t stat;

  // controller
  rclfr_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .cfg_valid (cfg_valid),
    .cfg_ready (cfg_ready),
    .stat      (stat),
    .cmd       (cmd)
  );

  // datapath
  rclfr_datapath u_datapath (
    .clk           (clk),
    .rst           (rst),
    .cmd           (cmd),
    .stat          (stat),
    .rx_byte       (rx_byte),
    .gap_before    (gap_before),
    .device_id     (device_id),
    .out_stall     (out_stall),
    .out_valid     (out_valid),
    .result_kind   (result_kind),
    .error_code    (error_code),
    .channel_byte  (channel_byte),
    .byte_position (byte_position),
    .missing_flag  (missing_flag),
    .failsafe_flag (failsafe_flag),
    .last_of_run   (last_of_run)
  );

endmodule

`default_nettype wire

>>> tb/sv/rc_link_frame_receiver_core_tb.sv
// testbench for rc_link_frame_receiver_core: frame stimulus, parser prediction, result checking
`timescale 1ns / 1ps

module rc_link_frame_receiver_core_tb;
  import rclfr_pkg::*;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int SETTLE_WAIT  = 40;
  localparam int REPORT_LIMIT = 10;

  // one received byte with its line gap flag
  typedef struct packed {
    logic [7:0] b;
    logic       gap;
  } rx_item_t;

  // one result as the output port shows it
  typedef struct packed {
    rclfr_kind_t      kind;
    rclfr_err_t       code;
    logic [7:0]       data;
    logic [POS_W-1:0] pos;
    logic             miss;
    logic             fs;
    logic             last;
  } rx_result_t;

  logic             clk = 1'b0;
  logic             rst = 1'b1;
  logic             in_valid = 1'b0;
  logic             in_stall;
  logic [7:0]       rx_byte = 8'h00;
  logic             gap_before = 1'b0;
  logic             out_valid;
  logic             out_stall = 1'b0;
  logic [1:0]       result_kind;
  logic [2:0]       error_code;
  logic [7:0]       channel_byte;
  logic [POS_W-1:0] byte_position;
  logic             missing_flag;
  logic             failsafe_flag;
  logic             last_of_run;
  logic             cfg_valid = 1'b0;
  logic             cfg_ready;
  logic [7:0]       device_id = 8'h00;

  // bytes waiting to be offered and results waiting to arrive
  rx_item_t   bytes_to_send[$];
  rx_result_t results_due[$];
  rx_item_t   next_item;

  // parser state mirrored by the predictor
  logic [IDX_W-1:0] rx_idx = '0;
  logic [IDX_W-1:0] frm_len = '0;
  logic             downlink = 1'b0;
  logic [CNT_W-1:0] hdr_channels = '0;
  logic [7:0]       sum_acc = 8'h00;
  logic [7:0]       frame_copy[STORE_DEPTH];
  logic [7:0]       sensor_id = 8'h00;

  // idling and hold-off controls
  int send_idle_pct = 0;
  int stall_pct = 0;
  int hold_req = 0;
  int hold_left = 0;
  bit force_gap = 1'b0;

  // bookkeeping
  int cycle_count = 0;
  int mismatch_count = 0;
  int bytes_queued = 0;
  int bytes_taken = 0;
  int data_seen = 0;
  int polls_seen = 0;
  int errors_seen = 0;

  rc_link_frame_receiver_core dut (
    .clk           (clk),
    .rst           (rst),
    .in_valid      (in_valid),
    .in_stall      (in_stall),
    .rx_byte       (rx_byte),
    .gap_before    (gap_before),
    .out_valid     (out_valid),
    .out_stall     (out_stall),
    .result_kind   (result_kind),
    .error_code    (error_code),
    .channel_byte  (channel_byte),
    .byte_position (byte_position),
    .missing_flag  (missing_flag),
    .failsafe_flag (failsafe_flag),
    .last_of_run   (last_of_run),
    .cfg_valid     (cfg_valid),
    .cfg_ready     (cfg_ready),
    .device_id     (device_id)
  );

  // 20 ns clock
  always begin
    #10 clk = 1'b1;
    #10 clk = 1'b0;
  end

  // run time limit
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d results still due", cycle_count,
               results_due.size());
      $display("FAIL");
      $finish;
    end
  end

  // 8-bit sum with end-around carry
  function automatic logic [7:0] eac_add(input logic [7:0] a, input logic [7:0] b);
    logic [8:0] s;
    s = {1'b0, a} + {1'b0, b};
    return s[7:0] + {7'd0, s[8]};
  endfunction

  function automatic rx_result_t error_result(input rclfr_err_t code);
    rx_result_t r;
    r = '0;
    r.kind = KIND_ERROR;
    r.code = code;
    r.last = 1'b1;
    return r;
  endfunction

  // frame parser prediction for one accepted byte
  task automatic parse_rx_byte(input logic [7:0] b, input logic gap);
    rx_result_t r;
    if (gap) rx_idx = '0;
    if (rx_idx == 0) begin
      case (b)
        LEN_CODE_8CH: begin
          frm_len = LEN_8CH; hdr_channels = CH_8; downlink = 1'b0;
        end
        LEN_CODE_16CH: begin
          frm_len = LEN_16CH; hdr_channels = CH_16; downlink = 1'b0;
        end
        LEN_CODE_24CH: begin
          frm_len = LEN_24CH; hdr_channels = CH_24; downlink = 1'b0;
        end
        LEN_CODE_DL: begin
          frm_len = LEN_DL; downlink = 1'b1;
        end
        default: begin
          results_due.push_back(error_result(ERR_LENGTH));
          return;
        end
      endcase
      sum_acc = 8'h00;
    end else if (rx_idx == 1 && !downlink && b != TYPE_BYTE) begin
      rx_idx = '0;
      results_due.push_back(error_result(ERR_TYPE));
      return;
    end
    // bytes past the store only enter the sum
    if (rx_idx < STORE_DEPTH) frame_copy[rx_idx] = b;
    if (rx_idx != 0) sum_acc = eac_add(sum_acc, b);
    rx_idx = rx_idx + 1'b1;
    if (frm_len > LEN_MIN && rx_idx == frm_len) begin
      rx_idx = '0;
      if (sum_acc != SUM_GOOD) begin
        results_due.push_back(error_result(ERR_CHECKSUM));
      end else if (hdr_channels != CH_16) begin
        results_due.push_back(error_result(ERR_CHANNELS));
      end else if (downlink) begin
        if (frame_copy[SLOT_ID] == sensor_id && frame_copy[SLOT_PRIM] == PRIM_POLL) begin
          r = '0;
          r.kind = KIND_POLL;
          r.code = ERR_NONE;
          r.last = 1'b1;
          results_due.push_back(r);
        end
      end else begin
        for (int k = 0; k < RC_DATA_BYTES; k++) begin
          r = '0;
          r.kind = KIND_DATA;
          r.code = ERR_NONE;
          r.data = frame_copy[k + 1];
          r.pos  = POS_W'(k);
          r.miss = frame_copy[SLOT_FLAGS][2];
          r.fs   = frame_copy[SLOT_FLAGS][3];
          r.last = (k == RC_DATA_BYTES - 1);
          results_due.push_back(r);
        end
      end
    end
  endtask

  task automatic report_mismatch(input string why, input rx_result_t want,
                                 input rx_result_t seen);
    mismatch_count++;
    if (mismatch_count <= REPORT_LIMIT) begin
      $display("%0t %s: exp kind=%0d err=%0d byte=%02h pos=%0d miss=%b fs=%b last=%b",
               $realtime, why, want.kind, want.code, want.data, want.pos, want.miss,
               want.fs, want.last);
      $display("    got kind=%0d err=%0d byte=%02h pos=%0d miss=%b fs=%b last=%b",
               seen.kind, seen.code, seen.data, seen.pos, seen.miss, seen.fs, seen.last);
    end
  endtask

  // byte driver: next request once the current one is taken
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else if (!in_valid || !in_stall) begin
      if (bytes_to_send.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
        next_item = bytes_to_send.pop_front();
        in_valid   <= 1'b1;
        rx_byte    <= next_item.b;
        gap_before <= next_item.gap;
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // output stall: random, or a long hold-off when asked
  always @(posedge clk) begin
    if (hold_left != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_left - 1;
    end else if (hold_req != 0) begin
      out_stall <= 1'b1;
      hold_left <= hold_req - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // monitor: predict on accepted bytes, check accepted results
  always @(posedge clk) begin
    rx_result_t seen;
    rx_result_t want;
    if (!rst) begin
      if (in_valid && !in_stall) begin
        bytes_taken++;
        parse_rx_byte(rx_byte, gap_before);
      end
      if (out_valid && !out_stall) begin
        seen.kind = rclfr_kind_t'(result_kind);
        seen.code = rclfr_err_t'(error_code);
        seen.data = channel_byte;
        seen.pos  = byte_position;
        seen.miss = missing_flag;
        seen.fs   = failsafe_flag;
        seen.last = last_of_run;
        case (seen.kind)
          KIND_DATA:  data_seen++;
          KIND_POLL:  polls_seen++;
          default:    errors_seen++;
        endcase
        if (results_due.size() == 0) begin
          report_mismatch("result with nothing due", '0, seen);
        end else begin
          want = results_due.pop_front();
          if (seen !== want) report_mismatch("result mismatch", want, seen);
        end
      end
    end
  end

  task automatic queue_byte(input logic [7:0] b, input logic gap);
    rx_item_t it;
    it.b = b;
    it.gap = gap;
    bytes_to_send.push_back(it);
    bytes_queued++;
  endtask

  // build a frame with random body; sent = 0 sends it whole, else only the first bytes
  task automatic queue_frame(input logic [7:0] code, input int sent, input logic [7:0] b1,
                             input logic [7:0] b2, input bit sum_ok, input bit lead_gap);
    logic [7:0] fb[0:37];
    logic [7:0] sum;
    int len;
    int n;
    case (code)
      LEN_CODE_8CH:  len = LEN_8CH;
      LEN_CODE_16CH: len = LEN_16CH;
      LEN_CODE_24CH: len = LEN_24CH;
      default:       len = LEN_DL;
    endcase
    fb[0] = code;
    fb[1] = b1;
    fb[2] = b2;
    for (int k = 3; k < len - 1; k++) fb[k] = 8'($urandom);
    sum = 8'h00;
    for (int k = 1; k < len - 1; k++) sum = eac_add(sum, fb[k]);
    // complement closes the sum at all ones; one more breaks it
    fb[len - 1] = sum_ok ? ~sum : ~sum + 8'd1;
    n = (sent <= 0 || sent > len) ? len : sent;
    for (int k = 0; k < n; k++) queue_byte(fb[k], (k == 0) ? lead_gap : 1'b0);
  endtask

  task automatic write_device_id(input logic [7:0] id);
    @(posedge clk);
    cfg_valid <= 1'b1;
    device_id <= id;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 1'b0;
    sensor_id = id;
  endtask

  // wait until every byte is taken and every result has come, then let the block settle
  task automatic wait_drained();
    do @(posedge clk);
    while (bytes_to_send.size() != 0 || in_valid || results_due.size() != 0);
    repeat (SETTLE_WAIT) @(posedge clk);
  endtask

  task automatic hold_output(input int cycles);
    @(posedge clk);
    hold_req <= cycles;
    @(posedge clk);
    hold_req <= 0;
  endtask

  // random frame mix, mostly well-formed frames with random bodies
  task automatic run_random(input int target);
    int start;
    int pick;
    bit lead;
    logic [7:0] id;
    logic [7:0] prim;
    start = bytes_queued;
    while (bytes_queued - start < target) begin
      pick = $urandom_range(99);
      lead = force_gap ? 1'b1 : 1'($urandom_range(1));
      force_gap = 1'b0;
      if (pick < 35) begin
        queue_frame(LEN_CODE_16CH, 0, TYPE_BYTE, 8'($urandom), 1'b1, lead);
      end else if (pick < 55) begin
        id   = ($urandom_range(3) != 0) ? sensor_id : 8'($urandom);
        prim = ($urandom_range(4) != 0) ? PRIM_POLL : 8'($urandom);
        queue_frame(LEN_CODE_DL, 0, id, prim, ($urandom_range(6) != 0), lead);
      end else if (pick < 65) begin
        queue_frame(LEN_CODE_16CH, 0, TYPE_BYTE, 8'($urandom), 1'b0, lead);
      end else if (pick < 73) begin
        queue_frame($urandom_range(1) ? LEN_CODE_8CH : LEN_CODE_24CH, 0, TYPE_BYTE,
                    8'($urandom), 1'b1, lead);
      end else if (pick < 81) begin
        queue_frame(LEN_CODE_16CH, 2, 8'($urandom_range(254)), 8'h00, 1'b1, lead);
      end else if (pick < 89) begin
        queue_frame(LEN_CODE_16CH, $urandom_range(3, 26), TYPE_BYTE, 8'($urandom),
                    1'b1, lead);
        force_gap = 1'b1;
      end else begin
        repeat ($urandom_range(1, 4)) queue_byte(8'($urandom), 1'($urandom_range(1)));
        force_gap = 1'b1;
      end
    end
  endtask

  // stimulus sequence
  initial begin
    repeat (5) @(posedge clk);
    rst <= 1'b0;

    // directed cases, sender mostly busy, receiver stalling half the time
    send_idle_pct = 6;
    stall_pct = 51;
    write_device_id(8'hFF);
    // poll before any 16-channel header is refused
    queue_frame(LEN_CODE_DL, 0, 8'hFF, PRIM_POLL, 1'b1, 1'b1);
    // bad length codes at both extremes
    queue_byte(8'h00, 1'b1);
    queue_byte(8'hFF, 1'b0);
    // 8 and 24 channel frames pass the sum but fail the channel count
    queue_frame(LEN_CODE_8CH, 0, TYPE_BYTE, 8'h00, 1'b1, 1'b0);
    queue_frame(LEN_CODE_24CH, 0, TYPE_BYTE, 8'hFF, 1'b1, 1'b1);
    // good 16 channel frame, then polls with match, other id, other prim
    queue_frame(LEN_CODE_16CH, 0, TYPE_BYTE, 8'h00, 1'b1, 1'b1);
    queue_frame(LEN_CODE_DL, 0, 8'hFF, PRIM_POLL, 1'b1, 1'b0);
    queue_frame(LEN_CODE_DL, 0, 8'h00, PRIM_POLL, 1'b1, 1'b0);
    queue_frame(LEN_CODE_DL, 0, 8'hFF, 8'h11, 1'b1, 1'b0);
    // bad type byte, bad checksum
    queue_frame(LEN_CODE_16CH, 2, 8'h00, 8'h00, 1'b1, 1'b0);
    queue_frame(LEN_CODE_16CH, 0, TYPE_BYTE, 8'hFF, 1'b0, 1'b0);
    // line gap cuts a frame short and restarts assembly
    queue_frame(LEN_CODE_16CH, 10, TYPE_BYTE, 8'h5A, 1'b1, 1'b0);
    queue_frame(LEN_CODE_16CH, 0, TYPE_BYTE, 8'hA5, 1'b1, 1'b1);
    queue_frame(LEN_CODE_DL, 0, 8'hFF, PRIM_POLL, 1'b0, 1'b0);
    wait_drained();

    // random, receiver often stalled, with one long hold-off while bytes keep coming
    write_device_id(8'h00);
    run_random(16);
    hold_output(400);
    wait_drained();

    // random, sender often idle, with a full drain halfway
    send_idle_pct = 51;
    stall_pct = 6;
    write_device_id(8'($urandom));
    run_random(8);
    wait_drained();
    run_random(8);
    wait_drained();

    // random, back to back on both sides
    send_idle_pct = 0;
    stall_pct = 0;
    write_device_id(8'hA5);
    run_random(16);
    wait_drained();

    if (results_due.size() != 0) mismatch_count += results_due.size();
    $display("covered %0d bytes: %0d channel data results, %0d polls, %0d frame errors",
             bytes_taken, data_seen, polls_seen, errors_seen);
    $display("device ids 00, ff, a5 and one random; three idle mixes and a long output hold");
    if (mismatch_count == 0) begin
      $display("PASS");
    end else begin
      $display("%0d mismatches", mismatch_count);
      $display("FAIL");
    end
    $finish;
  end

endmodule
